### rtl/fss_pkg.sv
package fss_pkg;

   localparam int TABLE_DEPTH_DEF = 64;
   localparam int KEY_BITS_DEF    = 16;

   localparam int COUNT_W = 7;
   localparam int INDEX_W = 6;
   localparam int KEY_W   = 16;
   localparam int FIB_W   = 8;
   localparam int PROBE_W = 9;

   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   typedef struct packed {
      logic               func;
      logic [INDEX_W-1:0] entry_index;
      logic [KEY_W-1:0]   key_value;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] found_index;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GROW,
      ST_PROBE_RD,
      ST_PROBE_CMP,
      ST_FINAL,
      ST_FINAL_CMP,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic write;
      logic start;
      logic grow;
      logic rd_probe;
      logic rd_final;
      logic step;
      logic check;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic fib_lt_count;
      logic fib_gt1;
      logic fib1_gt1;
      logic fib2_gt1;
      logic probed_lt;
      logic probed_gt;
      logic final_ok;
      logic out_free;
   } dp_sts_type;

endpackage

### rtl/fss_ctrl.sv
module fss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_func,
   output logic                req_stall,
   input  fss_pkg::dp_sts_type sts,
   output fss_pkg::dp_cmd_type cmd
);
   import fss_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_func == FUNC_WRITE) begin
                  cmd.write = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = ST_GROW;
               end
            end
         end
         ST_GROW: begin
            if (sts.fib_lt_count) begin
               cmd.grow = 1'b1;
            end else if (sts.fib_gt1) begin
               state_in = ST_PROBE_RD;
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_PROBE_RD: begin
            cmd.rd_probe = 1'b1;
            state_in     = ST_PROBE_CMP;
         end
         ST_PROBE_CMP: begin
            cmd.step = 1'b1;
            if (sts.probed_lt) begin
               state_in = sts.fib1_gt1 ? ST_PROBE_RD : ST_FINAL;
            end else if (sts.probed_gt) begin
               state_in = sts.fib2_gt1 ? ST_PROBE_RD : ST_FINAL;
            end else begin
               state_in = ST_OUTPUT;
            end
         end
         ST_FINAL: begin
            if (sts.final_ok) begin
               cmd.rd_final = 1'b1;
               state_in     = ST_FINAL_CMP;
            end else begin
               state_in = ST_OUTPUT;
            end
         end
         ST_FINAL_CMP: begin
            cmd.check = 1'b1;
            state_in  = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/fss_dpath.sv
module fss_dpath #(
   parameter int TABLE_DEPTH = fss_pkg::TABLE_DEPTH_DEF,
   parameter int KEY_BITS    = fss_pkg::KEY_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fss_pkg::req_type            req_data,
   input  logic                        csr_write,
   input  logic [fss_pkg::COUNT_W-1:0] csr_data,
   input  fss_pkg::dp_cmd_type         cmd,
   output fss_pkg::dp_sts_type         sts,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output fss_pkg::rsp_type            rsp_data
);
   import fss_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic [KEY_BITS-1:0] key_mem [TABLE_DEPTH];
   logic [KEY_BITS-1:0] rd_data_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic [IDX_W-1:0]    wr_addr;
   logic                wr_en;

   logic [COUNT_W-1:0] entries_ff, entries_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [FIB_W-1:0]   fib_ff, fib_in;
   logic [FIB_W-1:0]   fib1_ff, fib1_in;
   logic [FIB_W-1:0]   fib2_ff, fib2_in;
   logic [FIB_W-1:0]   op1_ff, op1_in;
   logic [PROBE_W-1:0] probe_ff, probe_in;
   logic               found_ff, found_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [PROBE_W-1:0] probe_raw;
   logic [PROBE_W-1:0] probe_lim;
   logic [PROBE_W-1:0] probe;
   logic               probed_lt;
   logic               probed_gt;

   // table port
   assign wr_en   = cmd.write && (32'(req_data.entry_index) < TABLE_DEPTH);
   assign wr_addr = IDX_W'(req_data.entry_index);
   assign rd_addr = cmd.rd_final ? IDX_W'(op1_ff) : IDX_W'(probe);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= KEY_BITS'(req_data.key_value);
      end
      if (cmd.rd_probe || cmd.rd_final) begin
         rd_data_ff <= key_mem[rd_addr];
      end
   end

   // probe position, clamped to the last entry in use
   assign probe_raw = PROBE_W'(op1_ff) + PROBE_W'(fib2_ff) - PROBE_W'(1);
   assign probe_lim = PROBE_W'(count_ff) - PROBE_W'(1);
   assign probe     = (probe_raw > probe_lim) ? probe_lim : probe_raw;

   assign probed_lt = rd_data_ff < key_ff;
   assign probed_gt = rd_data_ff > key_ff;

   always_comb begin
      entries_in   = entries_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      fib_in       = fib_ff;
      fib1_in      = fib1_ff;
      fib2_in      = fib2_ff;
      op1_in       = op1_ff;
      probe_in     = probe_ff;
      found_in     = found_ff;
      index_in     = index_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (csr_write) begin
         entries_in = csr_data;
      end

      if (cmd.start) begin
         if (32'(entries_ff) > TABLE_DEPTH) begin
            count_in = COUNT_W'(TABLE_DEPTH);
         end else begin
            count_in = entries_ff;
         end
         key_in   = KEY_BITS'(req_data.key_value);
         fib2_in  = '0;
         fib1_in  = FIB_W'(1);
         fib_in   = FIB_W'(1);
         op1_in   = '0;
         found_in = 1'b0;
         index_in = '0;
      end

      if (cmd.grow) begin
         fib2_in = fib1_ff;
         fib1_in = fib_ff;
         fib_in  = fib1_ff + fib_ff;
      end

      if (cmd.rd_probe) begin
         probe_in = probe;
      end

      if (cmd.rd_final) begin
         probe_in = PROBE_W'(op1_ff);
      end

      if (cmd.step) begin
         if (probed_lt) begin
            fib_in  = fib1_ff;
            fib1_in = fib2_ff;
            fib2_in = fib1_ff - fib2_ff;
            op1_in  = FIB_W'(probe_ff) + FIB_W'(1);
         end else if (probed_gt) begin
            fib_in  = fib2_ff;
            fib1_in = fib1_ff - fib2_ff;
            fib2_in = fib2_ff - (fib1_ff - fib2_ff);
         end else begin
            found_in = 1'b1;
            index_in = INDEX_W'(probe_ff);
         end
      end

      if (cmd.check && !probed_lt && !probed_gt) begin
         found_in = 1'b1;
         index_in = INDEX_W'(probe_ff);
      end

      if (cmd.out_load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.found       = found_ff;
         rsp_data_in.found_index = index_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         entries_ff   <= entries_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      count_ff    <= count_in;
      key_ff      <= key_in;
      fib_ff      <= fib_in;
      fib1_ff     <= fib1_in;
      fib2_ff     <= fib2_in;
      op1_ff      <= op1_in;
      probe_ff    <= probe_in;
      found_ff    <= found_in;
      index_ff    <= index_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      sts.fib_lt_count = fib_ff < FIB_W'(count_ff);
      sts.fib_gt1      = fib_ff > FIB_W'(1);
      sts.fib1_gt1     = fib1_ff > FIB_W'(1);
      sts.fib2_gt1     = fib2_ff > FIB_W'(1);
      sts.probed_lt    = probed_lt;
      sts.probed_gt    = probed_gt;
      sts.final_ok     = (fib1_ff == FIB_W'(1)) && (op1_ff < FIB_W'(count_ff));
      sts.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/fibonacci_search_sorted_table.sv
// Sorted key table with Fibonacci search.
// req channel (req_valid, req_stall, req_data): an item either writes one
// table entry (func write) or searches for a key over the entries in use.
// rsp channel (rsp_valid, rsp_stall, rsp_data): one item per search with a
// found flag and the index of the match; a write gives no item.
// csr channel (csr_valid, csr_ready, csr_data): sets entries_in_use; always
// ready, to be written only while the block is idle.
// A write item is taken in the idle state, which it does not leave. A search
// grows the Fibonacci numbers up to the count, then probes the table
// (registered memory read, then compare) until a match or the last check,
// which may read the table once more and compare; the result is then loaded
// into the output register. The next item is taken in the cycle rsp_valid
// rises. One search runs at a time and req_stall is high for its duration;
// probes use the single-port table read.
// The result sits in an output register; while rsp_stall is high it holds,
// and the next item can already be taken, finishing only once it has left.
// Reset clears the controller, the output valid and entries_in_use; table
// contents are undefined until written.
module fibonacci_search_sorted_table #(
   parameter int TABLE_DEPTH = fss_pkg::TABLE_DEPTH_DEF,
   parameter int KEY_BITS    = fss_pkg::KEY_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  fss_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output fss_pkg::rsp_type            rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [fss_pkg::COUNT_W-1:0] csr_data
);
   import fss_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   assign csr_ready = 1'b1;

   fss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fss_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
